/* hw/rtl/ccr_pkg.sv */
package ccr_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646E;
  localparam logic [31:0] SIGMA2 = 32'h79622D32;
  localparam logic [31:0] SIGMA3 = 32'h6B206574;

  localparam int NUM_CFG = 5;
  localparam logic [2:0] CFG_KEY01 = 3'd0;
  localparam logic [2:0] CFG_KEY23 = 3'd1;
  localparam logic [2:0] CFG_KEY45 = 3'd2;
  localparam logic [2:0] CFG_KEY67 = 3'd3;
  localparam logic [2:0] CFG_NONCE = 3'd4;

  // Request from the sequencer to the shared 32-bit divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

/* hw/rtl/chacha20_bounded_random_unit.sv */
// ChaCha20 bounded random unit.
// Input channel: in_valid/in_ready with in_upper_bound; one word per request.
// Output channel: out_valid/out_ready with out_random_value, one word per request.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects key
// word pairs 0..3 or the nonce (4); writes take effect at the next refill.
// A request first takes one 32-bit remainder to form the rejection limit, then
// draws words from the buffer, then takes a second 32-bit remainder for the
// result. A keystream refill of ceil(ROUNDS/2) double rounds runs once every
// 16 words.
// Bounds of 0 or 1 answer zero and draw no word.
// The unit handles one request at a time; in_ready is low until the result
// is taken. If the receiver stalls, the result waits in the output register.
// After reset the block counter is zero and the buffer is empty, so the first
// draw triggers a refill.
module chacha20_bounded_random_unit
  import ccr_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_upper_bound,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_LIMIT, S_DRAW, S_FILL, S_MOD, S_OUT} state_t;

  state_t state_r;
  logic [63:0] cfg_r [NUM_CFG];
  logic [63:0] ctr_r;
  logic [4:0]  widx_r;
  logic [31:0] bound_r;
  logic [31:0] limit_r;
  logic [31:0] res_r;
  logic        wait_r;
  logic [15:0][31:0] buf_r;

  div_req_t dreq;
  div_rsp_t drsp;
  logic core_start, core_done;
  logic [15:0][31:0] init_words, core_words;
  logic [31:0] word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_random_value = res_r;
  assign word = buf_r[widx_r[3:0]];

  always_comb begin
    init_words[0] = SIGMA0;
    init_words[1] = SIGMA1;
    init_words[2] = SIGMA2;
    init_words[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_words[4 + 2 * i] = cfg_r[i][31:0];
      init_words[5 + 2 * i] = cfg_r[i][63:32];
    end
    init_words[12] = ctr_r[31:0];
    init_words[13] = ctr_r[63:32];
    init_words[14] = cfg_r[CFG_NONCE][31:0];
    init_words[15] = cfg_r[CFG_NONCE][63:32];
  end

  always_comb begin
    dreq = '0;
    core_start = 1'b0;
    if (state_r == S_LIMIT && !wait_r) begin
      dreq.start = 1'b1;
      dreq.dividend = 32'hFFFFFFFF;
      dreq.divisor = bound_r;
    end else if (state_r == S_DRAW && !widx_r[4] && word < limit_r) begin
      dreq.start = 1'b1;
      dreq.dividend = word;
      dreq.divisor = bound_r;
    end
    if (state_r == S_DRAW && widx_r[4]) core_start = 1'b1;
  end

  ccr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  ccr_core #(.ROUNDS(ROUNDS)) u_core (
    .clk(clk), .rst_n(rst_n), .start(core_start), .init_words(init_words),
    .done(core_done), .key_words(core_words)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r   <= '0;
      widx_r  <= 5'd16;
      wait_r  <= 1'b0;
      for (int i = 0; i < NUM_CFG; i++) cfg_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_index < 3'(NUM_CFG)) cfg_r[cfg_index] <= cfg_data;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            bound_r <= in_upper_bound;
            wait_r  <= 1'b0;
            if (in_upper_bound <= 32'd1) begin
              res_r   <= '0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_LIMIT;
            end
          end
        end
        S_LIMIT: begin
          wait_r <= 1'b1;
          if (drsp.done) begin
            limit_r <= 32'hFFFFFFFF - drsp.rem;
            state_r <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (widx_r[4]) begin
            state_r <= S_FILL;
          end else begin
            widx_r <= widx_r + 5'd1;
            // A word at or above the limit is dropped and the next one drawn.
            if (word < limit_r) state_r <= S_MOD;
          end
        end
        S_FILL: begin
          if (core_done) begin
            buf_r   <= core_words;
            ctr_r   <= ctr_r + 64'd1;
            widx_r  <= '0;
            state_r <= S_DRAW;
          end
        end
        S_MOD: begin
          if (drsp.done) begin
            res_r   <= drsp.rem;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/ccr_core.sv */
// ChaCha block function: one quarter round per cycle over a 16-word register file,
// then the feed-forward add in the ADD state.
module ccr_core
  import ccr_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0][31:0] init_words,
  output logic              done,
  output logic [15:0][31:0] key_words
);

  localparam int DROUNDS = (ROUNDS + 1) / 2;
  localparam int QR_TOTAL = DROUNDS * 8;
  localparam int QW = $clog2(QR_TOTAL + 1);

  typedef enum logic [1:0] {IDLE, RUN, ADD} state_t;

  state_t state_r;
  logic [QW-1:0] qcnt_r;
  logic [15:0][31:0] w_r;
  logic [15:0][31:0] init_r;
  logic done_r;

  logic [2:0] qsel;
  logic [3:0] ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;

  assign qsel = qcnt_r[2:0];

  always_comb begin
    ia = {2'b00, qsel[1:0]};
    if (!qsel[2]) begin
      ib = 4'd4 + {2'b00, qsel[1:0]};
      ic = 4'd8 + {2'b00, qsel[1:0]};
      id = 4'd12 + {2'b00, qsel[1:0]};
    end else begin
      ib = 4'd4 + {2'b00, qsel[1:0] + 2'd1};
      ic = 4'd8 + {2'b00, qsel[1:0] + 2'd2};
      id = 4'd12 + {2'b00, qsel[1:0] + 2'd3};
    end
    a0 = w_r[ia] + w_r[ib];
    d0 = rotl(w_r[id] ^ a0, 16);
    c0 = w_r[ic] + d0;
    b0 = rotl(w_r[ib] ^ c0, 12);
    a1 = a0 + b0;
    d1 = rotl(d0 ^ a1, 8);
    c1 = c0 + d1;
    b1 = rotl(b0 ^ c1, 7);
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      qcnt_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (start) begin
            w_r     <= init_words;
            init_r  <= init_words;
            qcnt_r  <= '0;
            state_r <= RUN;
          end
        end
        RUN: begin
          w_r[ia] <= a2;
          w_r[ib] <= b2;
          w_r[ic] <= c2;
          w_r[id] <= d2;
          if (qcnt_r == QW'(QR_TOTAL - 1)) state_r <= ADD;
          qcnt_r <= qcnt_r + 1'b1;
        end
        ADD: begin
          for (int i = 0; i < 16; i++) w_r[i] <= w_r[i] + init_r[i];
          done_r  <= 1'b1;
          state_r <= IDLE;
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign key_words = w_r;

endmodule

/* hw/rtl/ccr_div.sv */
// Restoring 32-bit remainder, one quotient bit per cycle.
module ccr_div
  import ccr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] num_r;
  logic [31:0] den_r;
  logic [32:0] rem_r;
  logic        done_r;
  logic [32:0] trial;

  assign trial = {rem_r[31:0], num_r[31]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          num_r  <= req.dividend;
          den_r  <= req.divisor;
          rem_r  <= '0;
          cnt_r  <= 6'd32;
        end
      end else begin
        if (!trial[32]) rem_r <= {1'b0, trial[31:0]};
        else rem_r <= {rem_r[31:0], num_r[31]};
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[31:0];

endmodule
